### src/mffvd_pkg.sv
package mffvd_pkg;

    localparam int ATTR_SLOTS   = 1024;
    localparam int VERTEX_SLOTS = 1024;
    localparam int AW           = $clog2(ATTR_SLOTS);
    localparam int VW           = $clog2(VERTEX_SLOTS);
    localparam int ACW          = $clog2(ATTR_SLOTS + 1);
    localparam int VCW          = $clog2(VERTEX_SLOTS + 1);
    localparam int IDXW         = 10;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef enum logic [2:0] {
        REQ_POS   = 3'd0,
        REQ_NORM  = 3'd1,
        REQ_TEX   = 3'd2,
        REQ_FACE  = 3'd3,
        REQ_CLEAR = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_RESOLVE,
        ST_SEARCH,
        ST_DONE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [15:0] p;
        logic [15:0] t;
        logic [15:0] n;
    } t_refs;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] tu;
        logic [31:0] tv;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
    } t_vtx;

    function automatic logic [31:0] flip_v(input logic [31:0] v);
        logic signed [32:0] r;
        r = $signed({1'b0, Q_ONE}) - $signed({v[31], v});
        if (r > 33'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (r < -33'sd2147483648)
            return 32'h8000_0000;
        else
            return r[31:0];
    endfunction

endpackage

### src/mffvd_vtx_table.sv
module mffvd_vtx_table
    import mffvd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [VW-1:0] i_rd_addr,
    output logic          o_match,
    input  t_vtx          i_key,
    input  logic          i_wr_en,
    input  logic [VW-1:0] i_wr_addr,
    input  t_vtx          i_wr_data
);

    t_vtx r_mem [VERTEX_SLOTS];
    t_vtx r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // single shared comparator
    assign o_match = (r_rd == i_key);

endmodule

### src/mesh_face_fan_vertex_dedup.sv
// Mesh fan triangulator with unique-vertex deduplication.
// Input channel (i_valid/o_ready) carries one record: position, normal or
// texcoord entry, face corner, or clear. Output channel (o_valid/i_ready)
// carries triangle corners, three per triangle, the third with
// o_last_of_run set. Attribute records and clear are accepted in idle and
// may follow back to back.
// A face corner from the third on emits a triangle: each of its three
// corners is resolved from the attribute stores (ST_RD, ST_RESOLVE), then
// the vertex table is searched entry by entry through one comparator,
// one entry a cycle, so a corner's time grows with the vertex count and
// the search loop over the table memory sets how long a triangle takes.
// The block takes one record at a time; o_ready is low while it works
// and while a corner waits on the output. A receiver stall holds the
// result and the sequencer. Reset and clear zero the fill counts and the
// pending face; store contents are never read above their counts, so no
// clearing pass is needed.
module mesh_face_fan_vertex_dedup
    import mffvd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_attr_x,
    input  logic signed [31:0] i_attr_y,
    input  logic signed [31:0] i_attr_z,
    input  logic [15:0]        i_pos_ref,
    input  logic [15:0]        i_tex_ref,
    input  logic [15:0]        i_norm_ref,
    input  logic               i_last_corner,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [IDXW-1:0]    o_vertex_index,
    output logic               o_is_new,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_tex_u,
    output logic signed [31:0] o_tex_v,
    output logic signed [31:0] o_norm_x,
    output logic signed [31:0] o_norm_y,
    output logic signed [31:0] o_norm_z,
    output logic               o_table_full,
    output logic               o_last_of_run
);

    logic [95:0] r_pos_mem  [ATTR_SLOTS];
    logic [95:0] r_norm_mem [ATTR_SLOTS];
    logic [63:0] r_tex_mem  [ATTR_SLOTS];
    logic [95:0] r_pos_rd, r_norm_rd;
    logic [63:0] r_tex_rd;

    t_state r_state, n_state;
    logic [ACW-1:0] r_pos_cnt, r_norm_cnt, r_tex_cnt;
    logic [VCW-1:0] r_vcnt;
    logic [VCW-1:0] r_k;
    logic [7:0]     r_ccnt;
    t_refs          r_first, r_prev, r_cur;
    logic [1:0]     r_sel;
    t_refs          w_refs;
    logic           r_pok, r_tok, r_nok;
    t_vtx           r_key;
    logic           r_found;
    logic [VW-1:0]  r_fidx;

    logic w_acc, w_match, w_rd_en, w_wr_en, w_emit;
    logic w_in_pos, w_in_norm, w_in_tex;

    assign w_acc = i_valid && o_ready;

    always_comb begin
        unique case (r_sel)
            2'd0:    w_refs = r_first;
            2'd1:    w_refs = r_prev;
            default: w_refs = r_cur;
        endcase
    end

    assign w_in_pos  = (w_refs.p != '0) && ({{(32-ACW){1'b0}}, r_pos_cnt} >= {16'd0, w_refs.p});
    assign w_in_tex  = (w_refs.t != '0) && ({{(32-ACW){1'b0}}, r_tex_cnt} >= {16'd0, w_refs.t});
    assign w_in_norm = (w_refs.n != '0) && ({{(32-ACW){1'b0}}, r_norm_cnt} >= {16'd0, w_refs.n});

    // attribute stores
    always_ff @(posedge i_clk) begin
        if (w_acc && i_req_type == REQ_POS && r_pos_cnt < ACW'(ATTR_SLOTS))
            r_pos_mem[r_pos_cnt[AW-1:0]] <= {i_attr_x, i_attr_y, i_attr_z};
        if (w_acc && i_req_type == REQ_NORM && r_norm_cnt < ACW'(ATTR_SLOTS))
            r_norm_mem[r_norm_cnt[AW-1:0]] <= {i_attr_x, i_attr_y, i_attr_z};
        if (w_acc && i_req_type == REQ_TEX && r_tex_cnt < ACW'(ATTR_SLOTS))
            r_tex_mem[r_tex_cnt[AW-1:0]] <= {i_attr_x, flip_v(i_attr_y)};
        r_pos_rd  <= r_pos_mem[AW'(w_refs.p - 16'd1)];
        r_tex_rd  <= r_tex_mem[AW'(w_refs.t - 16'd1)];
        r_norm_rd <= r_norm_mem[AW'(w_refs.n - 16'd1)];
    end

    assign w_rd_en = (r_state == ST_RESOLVE) || (r_state == ST_SEARCH);
    assign w_wr_en = (r_state == ST_DONE) && !r_found && (r_vcnt < VCW'(VERTEX_SLOTS));

    mffvd_vtx_table u_tbl (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_k[VW-1:0]),
        .o_match   (w_match),
        .i_key     (r_key),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_vcnt[VW-1:0]),
        .i_wr_data (r_key)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:
                if (w_acc && i_req_type == REQ_FACE && r_ccnt >= 8'd2) n_state = ST_RD;
            ST_RD:      n_state = ST_RESOLVE;
            ST_RESOLVE: n_state = (r_vcnt == '0) ? ST_DONE : ST_SEARCH;
            ST_SEARCH:
                if (w_match || r_k == r_vcnt) n_state = ST_DONE;
            ST_DONE:    n_state = ST_OUT;
            ST_OUT:
                if (i_ready) n_state = (r_sel == 2'd2) ? ST_IDLE : ST_RD;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_OUT);
    end

    assign w_emit = w_acc && i_req_type == REQ_FACE && r_ccnt >= 8'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pos_cnt  <= '0;
            r_norm_cnt <= '0;
            r_tex_cnt  <= '0;
            r_vcnt     <= '0;
            r_ccnt     <= '0;
            r_sel      <= '0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                unique case (i_req_type)
                    REQ_POS:
                        if (r_pos_cnt < ACW'(ATTR_SLOTS)) r_pos_cnt <= r_pos_cnt + 1'b1;
                    REQ_NORM:
                        if (r_norm_cnt < ACW'(ATTR_SLOTS)) r_norm_cnt <= r_norm_cnt + 1'b1;
                    REQ_TEX:
                        if (r_tex_cnt < ACW'(ATTR_SLOTS)) r_tex_cnt <= r_tex_cnt + 1'b1;
                    REQ_FACE: begin
                        if (i_last_corner)
                            r_ccnt <= '0;
                        else if (r_ccnt != 8'd255)
                            r_ccnt <= r_ccnt + 1'b1;
                    end
                    REQ_CLEAR: begin
                        r_pos_cnt  <= '0;
                        r_norm_cnt <= '0;
                        r_tex_cnt  <= '0;
                        r_vcnt     <= '0;
                        r_ccnt     <= '0;
                    end
                    default: ;
                endcase
            end
            if (w_emit) r_sel <= 2'd0;
            if (r_state == ST_OUT && i_ready) r_sel <= r_sel + 1'b1;
            if (w_wr_en) r_vcnt <= r_vcnt + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_acc && i_req_type == REQ_FACE) begin
            r_cur  <= '{p: i_pos_ref, t: i_tex_ref, n: i_norm_ref};
            if (r_ccnt == 8'd0)
                r_first <= '{p: i_pos_ref, t: i_tex_ref, n: i_norm_ref};
            else if (r_ccnt == 8'd1)
                r_prev <= '{p: i_pos_ref, t: i_tex_ref, n: i_norm_ref};
        end
        // shift previous once the third corner has gone
        if (r_state == ST_OUT && i_ready && r_sel == 2'd2)
            r_prev <= r_cur;
        if (r_state == ST_RD) begin
            r_pok <= w_in_pos;
            r_tok <= w_in_tex;
            r_nok <= w_in_norm;
            // point the table read at entry 0 for the first compare
            r_k   <= '0;
        end
        if (r_state == ST_RESOLVE) begin
            r_key.px <= r_pok ? r_pos_rd[95:64] : '0;
            r_key.py <= r_pok ? r_pos_rd[63:32] : '0;
            r_key.pz <= r_pok ? r_pos_rd[31:0]  : '0;
            r_key.tu <= r_tok ? r_tex_rd[63:32] : '0;
            r_key.tv <= r_tok ? r_tex_rd[31:0]  : '0;
            r_key.nx <= r_nok ? r_norm_rd[95:64] : '0;
            r_key.ny <= r_nok ? r_norm_rd[63:32] : '0;
            r_key.nz <= r_nok ? r_norm_rd[31:0]  : Q_ONE;
            r_k      <= VCW'(1);
            r_found  <= 1'b0;
        end
        if (r_state == ST_SEARCH) begin
            // compare result belongs to entry r_k - 1
            if (w_match) begin
                r_found <= 1'b1;
                r_fidx  <= VW'(r_k - 1'b1);
            end
            r_k <= r_k + 1'b1;
        end
        if (r_state == ST_DONE) begin
            o_last_of_run <= (r_sel == 2'd2);
            o_pos_x  <= r_key.px;
            o_pos_y  <= r_key.py;
            o_pos_z  <= r_key.pz;
            o_tex_u  <= r_key.tu;
            o_tex_v  <= r_key.tv;
            o_norm_x <= r_key.nx;
            o_norm_y <= r_key.ny;
            o_norm_z <= r_key.nz;
            if (r_found) begin
                o_vertex_index <= IDXW'(r_fidx);
                o_is_new       <= 1'b0;
                o_table_full   <= 1'b0;
            end else if (r_vcnt < VCW'(VERTEX_SLOTS)) begin
                o_vertex_index <= IDXW'(r_vcnt);
                o_is_new       <= 1'b1;
                o_table_full   <= 1'b0;
            end else begin
                o_vertex_index <= '0;
                o_is_new       <= 1'b0;
                o_table_full   <= 1'b1;
            end
        end
    end

endmodule

### tb/mesh_face_fan_vertex_dedup_tb.sv
module mesh_face_fan_vertex_dedup_tb;
    import mffvd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_req_type = REQ_POS;
    logic signed [31:0] i_attr_x = '0;
    logic signed [31:0] i_attr_y = '0;
    logic signed [31:0] i_attr_z = '0;
    logic [15:0]        i_pos_ref = '0;
    logic [15:0]        i_tex_ref = '0;
    logic [15:0]        i_norm_ref = '0;
    logic               i_last_corner = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [IDXW-1:0]    o_vertex_index;
    logic               o_is_new;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [31:0] o_tex_u, o_tex_v;
    logic signed [31:0] o_norm_x, o_norm_y, o_norm_z;
    logic               o_table_full;
    logic               o_last_of_run;

    mesh_face_fan_vertex_dedup uut (.*);

    always #1 i_clk = ~i_clk;

    typedef struct {
        logic [2:0]  req;
        logic [31:0] x, y, z;
        logic [15:0] p, t, n;
        logic        last;
        logic        drain;
    } t_record;

    typedef struct {
        logic [IDXW-1:0] idx;
        logic            is_new;
        t_vtx            v;
        logic            full;
        logic            last;
    } t_corner_out;

    t_record     record_q[$];
    t_corner_out corner_q[$];
    int          fail_count = 0;

    // shadow of the block's tables
    logic [31:0] pos_mem[3*ATTR_SLOTS];
    logic [31:0] norm_mem[3*ATTR_SLOTS];
    logic [31:0] tex_mem[2*ATTR_SLOTS];
    t_vtx        vtx_mem[VERTEX_SLOTS];
    int          n_pos, n_norm, n_tex, n_vtx, n_corners;
    t_refs       first_refs, prev_refs;

    function automatic logic [31:0] one_minus(input logic [31:0] v);
        longint r;
        r = 64'sd65536 - longint'($signed(v));
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic t_vtx lookup_vertex(input t_refs r);
        t_vtx v;
        v = '0;
        v.nz = Q_ONE;
        if (r.p >= 1 && r.p <= n_pos) begin
            v.px = pos_mem[3*(r.p-1)];
            v.py = pos_mem[3*(r.p-1)+1];
            v.pz = pos_mem[3*(r.p-1)+2];
        end
        if (r.t >= 1 && r.t <= n_tex) begin
            v.tu = tex_mem[2*(r.t-1)];
            v.tv = tex_mem[2*(r.t-1)+1];
        end
        if (r.n >= 1 && r.n <= n_norm) begin
            v.nx = norm_mem[3*(r.n-1)];
            v.ny = norm_mem[3*(r.n-1)+1];
            v.nz = norm_mem[3*(r.n-1)+2];
        end
        return v;
    endfunction

    task automatic dedup_corner(input t_refs r, input logic last);
        t_corner_out e;
        int k;
        bit hit;
        e = '{idx: '0, is_new: 1'b0, v: lookup_vertex(r), full: 1'b0, last: last};
        hit = 0;
        for (k = 0; k < n_vtx; k++) begin
            if (vtx_mem[k] == e.v) begin
                e.idx = k[IDXW-1:0];
                hit = 1;
                break;
            end
        end
        if (!hit) begin
            if (n_vtx < VERTEX_SLOTS) begin
                e.idx = n_vtx[IDXW-1:0];
                vtx_mem[n_vtx] = e.v;
                n_vtx++;
                e.is_new = 1'b1;
            end else begin
                e.full = 1'b1;
            end
        end
        corner_q.push_back(e);
    endtask

    task automatic apply_record(input t_record rec);
        t_refs cur;
        cur = '{p: rec.p, t: rec.t, n: rec.n};
        case (rec.req)
            REQ_POS: if (n_pos < ATTR_SLOTS) begin
                pos_mem[3*n_pos] = rec.x;
                pos_mem[3*n_pos+1] = rec.y;
                pos_mem[3*n_pos+2] = rec.z;
                n_pos++;
            end
            REQ_NORM: if (n_norm < ATTR_SLOTS) begin
                norm_mem[3*n_norm] = rec.x;
                norm_mem[3*n_norm+1] = rec.y;
                norm_mem[3*n_norm+2] = rec.z;
                n_norm++;
            end
            REQ_TEX: if (n_tex < ATTR_SLOTS) begin
                tex_mem[2*n_tex] = rec.x;
                tex_mem[2*n_tex+1] = one_minus(rec.y);
                n_tex++;
            end
            REQ_FACE: begin
                if (n_corners == 0) begin
                    first_refs = cur;
                end else if (n_corners == 1) begin
                    prev_refs = cur;
                end else begin
                    dedup_corner(first_refs, 1'b0);
                    dedup_corner(prev_refs, 1'b0);
                    dedup_corner(cur, 1'b1);
                    prev_refs = cur;
                end
                if (n_corners < 255) n_corners++;
                if (rec.last) begin
                    n_corners = 0;
                    first_refs = '0;
                    prev_refs = '0;
                end
            end
            REQ_CLEAR: begin
                n_pos = 0;
                n_norm = 0;
                n_tex = 0;
                n_vtx = 0;
                n_corners = 0;
                first_refs = '0;
                prev_refs = '0;
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                apply_record(record_q.pop_front());
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (record_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (record_q[0].drain && corner_q.size() != 0) begin
                    // hold until the block has delivered every triangle
                    i_valid <= 1'b0;
                end else begin
                    i_req_type    <= record_q[0].req;
                    i_attr_x      <= record_q[0].x;
                    i_attr_y      <= record_q[0].y;
                    i_attr_z      <= record_q[0].z;
                    i_pos_ref     <= record_q[0].p;
                    i_tex_ref     <= record_q[0].t;
                    i_norm_ref    <= record_q[0].n;
                    i_last_corner <= record_q[0].last;
                    i_valid       <= 1'b1;
                    send_gap = pick_gap();
                end
            end
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report(what, got, want);
    endtask

    // monitor
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_corner_out e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (corner_q.size() == 0) begin
                    report("unexpected transaction", 32'(o_vertex_index), '0);
                end else begin
                    e = corner_q.pop_front();
                    check_field("vertex_index", 32'(o_vertex_index), 32'(e.idx));
                    check_field("is_new", 32'(o_is_new), 32'(e.is_new));
                    check_field("pos_x", o_pos_x, e.v.px);
                    check_field("pos_y", o_pos_y, e.v.py);
                    check_field("pos_z", o_pos_z, e.v.pz);
                    check_field("tex_u", o_tex_u, e.v.tu);
                    check_field("tex_v", o_tex_v, e.v.tv);
                    check_field("norm_x", o_norm_x, e.v.nx);
                    check_field("norm_y", o_norm_y, e.v.ny);
                    check_field("norm_z", o_norm_z, e.v.nz);
                    check_field("table_full", 32'(o_table_full), 32'(e.full));
                    check_field("last_of_run", 32'(o_last_of_run), 32'(e.last));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    task automatic add(input logic [2:0] req, input logic [31:0] x, input logic [31:0] y,
                       input logic [31:0] z, input logic [15:0] p, input logic [15:0] t,
                       input logic [15:0] n, input logic last);
        record_q.push_back('{req: req, x: x, y: y, z: z, p: p, t: t, n: n,
                             last: last, drain: 1'b0});
    endtask

    function automatic logic [15:0] pick_ref(input int cnt);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'd0;
        if (r < 16) return 16'($urandom());
        return 16'($urandom_range(1, (cnt < 1) ? 1 : ((cnt > 12) ? 12 : cnt)));
    endfunction

    initial begin
        int gp, gt, gn, i, k, corners;
        n_pos = 0; n_norm = 0; n_tex = 0; n_vtx = 0; n_corners = 0;
        first_refs = '0;
        prev_refs = '0;

        // extremes of coordinates and the texture flip saturation
        add(REQ_POS, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0);
        add(REQ_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 1);
        add(REQ_NORM, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 0, 0, 0, 0);
        add(REQ_TEX, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add(REQ_TEX, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0, 0, 0, 0);
        add(REQ_TEX, 32'h1, 32'hFFFF_0000, 32'h0, 0, 0, 0, 0);
        // quad with missing and out-of-range references
        add(REQ_FACE, 0, 0, 0, 1, 1, 1, 0);
        add(REQ_FACE, 0, 0, 0, 2, 0, 0, 0);
        add(REQ_FACE, 0, 0, 0, 3, 2, 5, 0);
        add(REQ_FACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 1);
        // short faces
        add(REQ_FACE, 0, 0, 0, 1, 1, 1, 0);
        add(REQ_FACE, 0, 0, 0, 2, 2, 1, 1);
        add(REQ_FACE, 0, 0, 0, 2, 3, 1, 1);
        // attribute record inside a face
        add(REQ_FACE, 0, 0, 0, 1, 1, 1, 0);
        add(REQ_FACE, 0, 0, 0, 2, 2, 1, 0);
        add(REQ_POS, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_0001, 0, 0, 0, 0);
        add(REQ_FACE, 0, 0, 0, 3, 1, 1, 1);
        // unknown request codes
        add(3'd5, 32'h1234_5678, 32'h0, 32'h0, 1, 1, 1, 1);
        add(3'd6, 32'h0, 32'h0, 32'h0, 1, 1, 1, 0);
        add(3'd7, 32'h0, 32'h0, 32'h0, 2, 2, 2, 1);
        // clear inside a face
        add(REQ_FACE, 0, 0, 0, 1, 1, 1, 0);
        add(REQ_FACE, 0, 0, 0, 2, 2, 1, 0);
        add(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        add(REQ_FACE, 0, 0, 0, 1, 1, 1, 0);
        add(REQ_FACE, 0, 0, 0, 2, 2, 2, 0);
        add(REQ_FACE, 0, 0, 0, 3, 0, 1, 1);

        gp = 0; gt = 0; gn = 0;
        i = 0;
        while (i < 500) begin
            k = $urandom_range(0, 99);
            if (i >= 250 && i < 256) begin
                add(REQ_CLEAR, $urandom(), $urandom(), $urandom(), 16'($urandom()),
                    16'($urandom()), 16'($urandom()), 1'($urandom()));
                record_q[$].drain = 1'b1;
                gp = 0; gt = 0; gn = 0;
                i += 6;
            end else if (k < 30) begin
                case ($urandom_range(0, 2))
                    0: begin add(REQ_POS, $urandom(), $urandom(), $urandom(),
                                 16'($urandom()), 16'($urandom()), 16'($urandom()),
                                 1'($urandom())); gp++; end
                    1: begin add(REQ_NORM, $urandom(), $urandom(), $urandom(),
                                 16'($urandom()), 16'($urandom()), 16'($urandom()),
                                 1'($urandom())); gn++; end
                    default: begin add(REQ_TEX, $urandom(), $urandom(), $urandom(),
                                       16'($urandom()), 16'($urandom()),
                                       16'($urandom()), 1'($urandom())); gt++; end
                endcase
                i++;
            end else if (k < 88) begin
                corners = $urandom_range(1, 8);
                for (int c = 0; c < corners; c++)
                    add(REQ_FACE, $urandom(), $urandom(), $urandom(), pick_ref(gp),
                        pick_ref(gt), pick_ref(gn), c == corners - 1);
                i += corners;
            end else if (k < 90) begin
                add(REQ_CLEAR, $urandom(), $urandom(), $urandom(), 16'($urandom()),
                    16'($urandom()), 16'($urandom()), 1'($urandom()));
                gp = 0; gt = 0; gn = 0;
                i++;
            end else if (k < 95) begin
                add(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom(),
                    16'($urandom()), 16'($urandom()), 16'($urandom()), 1'($urandom()));
            end else begin
                // stray corner without a closing flag, which joins the next face's corners
                add(REQ_FACE, $urandom(), $urandom(), $urandom(), pick_ref(gp),
                    pick_ref(gt), pick_ref(gn), 1'b0);
                i++;
            end
        end

        // hold the last transaction until every triangle has come back
        add(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        record_q[$].drain = 1'b1;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(record_q.size() == 0 && !i_valid && corner_q.size() == 0))
            @(posedge i_clk);
        repeat (3 * (VERTEX_SLOTS + 8)) @(posedge i_clk);
        if (fail_count == 0 && corner_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
